// ===== hw/rtl/dllm_pkg.sv =====
// shared constants, codes and beat types for the linked list manager
`timescale 1ns / 1ps

package dllm_pkg;

	localparam int NODE_COUNT = 64;
	localparam int NODE_W     = 6;
	localparam int LINK_W     = 7;

	// link value meaning "no node"
	localparam logic [LINK_W-1:0] NO_NODE = LINK_W'(NODE_COUNT);

	localparam logic [1:0] CMD_ADD_FRONT = 2'd0;
	localparam logic [1:0] CMD_ADD_END   = 2'd1;
	localparam logic [1:0] CMD_REMOVE    = 2'd2;
	localparam logic [1:0] CMD_POP_FRONT = 2'd3;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_EMPTY      = 2'd1;
	localparam logic [1:0] ST_LISTED     = 2'd2;
	localparam logic [1:0] ST_NOT_LISTED = 2'd3;

	typedef struct packed {
		logic [1:0]        command;
		logic [NODE_W-1:0] node;
	} req_t;

	typedef struct packed {
		logic [LINK_W-1:0] taken_node;
		logic [1:0]        status;
		logic [LINK_W-1:0] head_node;
		logic [LINK_W-1:0] tail_node;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} ctrl_cmd_t;

endpackage

// ===== hw/rtl/dllm_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module dllm_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/dllm_ctrl.sv =====
// controller: sequences capture and commit of one command, owns the result valid
`timescale 1ns / 1ps

module dllm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output dllm_pkg::ctrl_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic rsp_valid_q;
	logic accept;
	logic commit;

	assign accept = (state_q == ST_IDLE) && req_valid;
	// result register free this cycle if empty or being drained
	assign commit = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall   = (state_q != ST_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign cmd.capture = accept;
	assign cmd.commit  = commit;

endmodule

// ===== hw/rtl/dllm_dpath.sv =====
// datapath: link tables, head and tail, membership bits and the result register
`timescale 1ns / 1ps

module dllm_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  dllm_pkg::req_t      req,
	input  dllm_pkg::ctrl_cmd_t cmd,
	output dllm_pkg::rsp_t      rsp
);

	localparam int NW = dllm_pkg::NODE_W;
	localparam int LW = dllm_pkg::LINK_W;

	logic [1:0]                    command_q;
	logic [NW-1:0]                 node_q;
	logic [LW-1:0]                 head_q;
	logic [LW-1:0]                 tail_q;
	logic [dllm_pkg::NODE_COUNT-1:0] on_list_q;
	dllm_pkg::rsp_t                rsp_q;

	logic [NW-1:0] rd_addr;
	logic [LW-1:0] next_rd;
	logic [LW-1:0] prev_rd;

	logic          next_we;
	logic [NW-1:0] next_waddr;
	logic [LW-1:0] next_wdata;
	logic          prev_we;
	logic [NW-1:0] prev_waddr;
	logic [LW-1:0] prev_wdata;

	logic [LW-1:0] head_d;
	logic [LW-1:0] tail_d;
	logic [LW-1:0] taken_d;
	logic [1:0]    status_d;
	logic          set_member;
	logic          clr_member;
	logic [NW-1:0] target;
	logic [LW-1:0] target_ext;
	logic [LW-1:0] p_link;
	logic [LW-1:0] q_link;
	logic          empty;
	logic          listed;

	// pop reads the head's links, everything else reads the named node
	assign rd_addr = (req.command == dllm_pkg::CMD_POP_FRONT) ? head_q[NW-1:0] : req.node;

	dllm_ram #(.WIDTH(LW), .DEPTH(dllm_pkg::NODE_COUNT)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.re    (cmd.capture),
		.raddr (rd_addr),
		.rdata (next_rd)
	);

	dllm_ram #(.WIDTH(LW), .DEPTH(dllm_pkg::NODE_COUNT)) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.re    (cmd.capture),
		.raddr (rd_addr),
		.rdata (prev_rd)
	);

	assign empty      = (head_q == dllm_pkg::NO_NODE);
	assign listed     = on_list_q[node_q];
	assign target     = (command_q == dllm_pkg::CMD_POP_FRONT) ? head_q[NW-1:0] : node_q;
	assign target_ext = {1'b0, target};
	// end links in the tables are not relied on, they follow from head and tail
	assign p_link = (target_ext == head_q) ? dllm_pkg::NO_NODE : prev_rd;
	assign q_link = (target_ext == tail_q) ? dllm_pkg::NO_NODE : next_rd;

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		taken_d    = dllm_pkg::NO_NODE;
		status_d   = dllm_pkg::ST_OK;
		set_member = 1'b0;
		clr_member = 1'b0;
		next_we    = 1'b0;
		next_waddr = target;
		next_wdata = q_link;
		prev_we    = 1'b0;
		prev_waddr = target;
		prev_wdata = p_link;
		unique case (command_q)
			dllm_pkg::CMD_ADD_FRONT, dllm_pkg::CMD_ADD_END: begin
				if (listed) begin
					status_d = dllm_pkg::ST_LISTED;
				end else begin
					set_member = 1'b1;
					if (empty) begin
						head_d = {1'b0, node_q};
						tail_d = {1'b0, node_q};
					end else if (command_q == dllm_pkg::CMD_ADD_FRONT) begin
						next_we    = 1'b1;
						next_waddr = node_q;
						next_wdata = head_q;
						prev_we    = 1'b1;
						prev_waddr = head_q[NW-1:0];
						prev_wdata = {1'b0, node_q};
						head_d     = {1'b0, node_q};
					end else begin
						prev_we    = 1'b1;
						prev_waddr = node_q;
						prev_wdata = tail_q;
						next_we    = 1'b1;
						next_waddr = tail_q[NW-1:0];
						next_wdata = {1'b0, node_q};
						tail_d     = {1'b0, node_q};
					end
				end
			end
			dllm_pkg::CMD_REMOVE, dllm_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					status_d = dllm_pkg::ST_EMPTY;
				end else if (command_q == dllm_pkg::CMD_REMOVE && !listed) begin
					status_d = dllm_pkg::ST_NOT_LISTED;
				end else begin
					clr_member = 1'b1;
					if (command_q == dllm_pkg::CMD_POP_FRONT) begin
						taken_d = head_q;
					end
					// splice neighbors around the target
					if (p_link != dllm_pkg::NO_NODE) begin
						next_we    = 1'b1;
						next_waddr = p_link[NW-1:0];
						next_wdata = q_link;
					end else begin
						head_d = q_link;
					end
					if (q_link != dllm_pkg::NO_NODE) begin
						prev_we    = 1'b1;
						prev_waddr = q_link[NW-1:0];
						prev_wdata = p_link;
					end else begin
						tail_d = p_link;
					end
				end
			end
			default: status_d = dllm_pkg::ST_OK;
		endcase
		next_we = next_we && cmd.commit;
		prev_we = prev_we && cmd.commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= dllm_pkg::NO_NODE;
			tail_q    <= dllm_pkg::NO_NODE;
			on_list_q <= '0;
		end else if (cmd.commit) begin
			head_q <= head_d;
			tail_q <= tail_d;
			if (set_member) begin
				on_list_q[node_q] <= 1'b1;
			end
			if (clr_member) begin
				on_list_q[target] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			command_q <= req.command;
			node_q    <= req.node;
		end
		if (cmd.commit) begin
			rsp_q.taken_node <= taken_d;
			rsp_q.status     <= status_d;
			rsp_q.head_node  <= head_d;
			rsp_q.tail_node  <= tail_d;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== hw/rtl/doubly_linked_list_manager_unit.sv =====
// Flow: an accepted command beat is captured and its links are read; in the execute state the
// result is committed into the result register, from which it leaves when not stalled.
// One command is in flight at a time; the link tables are rams with a
// registered read, read when the command is captured and written back when it commits.
// A stalled result holds the next command in its execute state until the result can move.
// Reset empties the list and clears all membership bits at once; the link
// tables are not cleared and need no pass.
`timescale 1ns / 1ps

module doubly_linked_list_manager_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  dllm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output dllm_pkg::rsp_t rsp
);

	dllm_pkg::ctrl_cmd_t cmd;

	dllm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	dllm_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	// one command in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("command accepted while another is in flight");

	a_head_tail_agree: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.head_node == dllm_pkg::NO_NODE) ==
			(rsp.tail_node == dllm_pkg::NO_NODE)))
		else $error("head and tail disagree on an empty list");

	a_taken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.taken_node != dllm_pkg::NO_NODE) |-> rsp.status == dllm_pkg::ST_OK)
		else $error("node taken with an error status");

	a_commit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid)
		else $error("committed result not presented");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the doubly linked list manager unit
`timescale 1ns / 1ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_BEATS   = 1100;
	localparam int HOLD_CYCLES    = 80;

	// tracks the list as the block should see it and holds the results it owes
	class list_scoreboard;
		logic [dllm_pkg::LINK_W-1:0] next_of [dllm_pkg::NODE_COUNT];
		logic [dllm_pkg::LINK_W-1:0] prev_of [dllm_pkg::NODE_COUNT];
		logic [dllm_pkg::LINK_W-1:0] head;
		logic [dllm_pkg::LINK_W-1:0] tail;
		bit                          member [dllm_pkg::NODE_COUNT];
		int                          listed;
		dllm_pkg::rsp_t              owed_q [$];
		int                          errors;

		function new();
			head   = dllm_pkg::NO_NODE;
			tail   = dllm_pkg::NO_NODE;
			listed = 0;
			errors = 0;
			foreach (member[i]) member[i] = 1'b0;
		endfunction

		function void unlink(int n);
			logic [dllm_pkg::LINK_W-1:0] p;
			logic [dllm_pkg::LINK_W-1:0] q;
			p = prev_of[n];
			q = next_of[n];
			if (p != dllm_pkg::NO_NODE) next_of[p] = q;
			else head = q;
			if (q != dllm_pkg::NO_NODE) prev_of[q] = p;
			else tail = p;
			next_of[n] = dllm_pkg::NO_NODE;
			prev_of[n] = dllm_pkg::NO_NODE;
			member[n]  = 1'b0;
			listed--;
		endfunction

		function void note_command(dllm_pkg::req_t c);
			dllm_pkg::rsp_t r;
			int             n;
			n            = int'(c.node);
			r.taken_node = dllm_pkg::NO_NODE;
			r.status     = dllm_pkg::ST_OK;
			case (c.command)
				dllm_pkg::CMD_ADD_FRONT, dllm_pkg::CMD_ADD_END: begin
					if (member[n]) begin
						r.status = dllm_pkg::ST_LISTED;
					end else begin
						if (head == dllm_pkg::NO_NODE) begin
							next_of[n] = dllm_pkg::NO_NODE;
							prev_of[n] = dllm_pkg::NO_NODE;
							head       = dllm_pkg::LINK_W'(n);
							tail       = dllm_pkg::LINK_W'(n);
						end else if (c.command == dllm_pkg::CMD_ADD_FRONT) begin
							prev_of[n]    = dllm_pkg::NO_NODE;
							next_of[n]    = head;
							prev_of[head] = dllm_pkg::LINK_W'(n);
							head          = dllm_pkg::LINK_W'(n);
						end else begin
							next_of[n]    = dllm_pkg::NO_NODE;
							prev_of[n]    = tail;
							next_of[tail] = dllm_pkg::LINK_W'(n);
							tail          = dllm_pkg::LINK_W'(n);
						end
						member[n] = 1'b1;
						listed++;
					end
				end
				dllm_pkg::CMD_REMOVE: begin
					if (head == dllm_pkg::NO_NODE) r.status = dllm_pkg::ST_EMPTY;
					else if (!member[n]) r.status = dllm_pkg::ST_NOT_LISTED;
					else unlink(n);
				end
				default: begin
					if (head == dllm_pkg::NO_NODE) begin
						r.status = dllm_pkg::ST_EMPTY;
					end else begin
						r.taken_node = head;
						unlink(int'(head));
					end
				end
			endcase
			r.head_node = head;
			r.tail_node = tail;
			owed_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [dllm_pkg::LINK_W-1:0] want,
				logic [dllm_pkg::LINK_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(dllm_pkg::rsp_t got);
			dllm_pkg::rsp_t want;
			if (owed_q.size() == 0) begin
				$error("result beat with nothing expected: %p", got);
				errors++;
			end else begin
				want = owed_q.pop_front();
				compare_field("taken_node", want.taken_node, got.taken_node);
				compare_field("status", dllm_pkg::LINK_W'(want.status),
					dllm_pkg::LINK_W'(got.status));
				compare_field("head_node", want.head_node, got.head_node);
				compare_field("tail_node", want.tail_node, got.tail_node);
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	dllm_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_stall;
	dllm_pkg::rsp_t rsp;

	list_scoreboard sb;
	int send_gap_pct;
	int stall_pct;
	int rand_idx;
	bit pressure_req;
	int hold_left;
	int quiet_cycles;

	doubly_linked_list_manager_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) sb.note_command(req);
			if (rsp_valid && !rsp_stall) sb.check_result(rsp);
		end
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: random stalls plus one long hold-off on request
	initial begin
		rsp_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (pressure_req) begin
				pressure_req = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic offer(input bit pick_random, input logic [1:0] cmd,
			input logic [dllm_pkg::NODE_W-1:0] node);
		int             gap;
		int             add_pct;
		dllm_pkg::req_t beat;
		gap = 0;
		while (send_gap_pct > 0 && gap < 20 && $urandom_range(99) < send_gap_pct) gap++;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		beat.command = cmd;
		beat.node    = node;
		if (pick_random) begin
			// drain window empties the list so empty cases keep coming
			if ((rand_idx % 250) >= 180) add_pct = 0;
			else if (sb.listed < 16) add_pct = 70;
			else if (sb.listed > 48) add_pct = 30;
			else add_pct = 50;
			beat.node = dllm_pkg::NODE_W'($urandom());
			if ($urandom_range(99) < add_pct) begin
				beat.command = $urandom_range(1) ? dllm_pkg::CMD_ADD_FRONT
					: dllm_pkg::CMD_ADD_END;
				if ($urandom_range(99) < 85 && sb.listed < dllm_pkg::NODE_COUNT)
					while (sb.member[beat.node]) beat.node = beat.node + 1'b1;
			end else begin
				beat.command = ($urandom_range(99) < 65) ? dllm_pkg::CMD_REMOVE
					: dllm_pkg::CMD_POP_FRONT;
				if (beat.command == dllm_pkg::CMD_REMOVE && sb.listed > 0
						&& $urandom_range(99) < 80)
					while (!sb.member[beat.node]) beat.node = beat.node + 1'b1;
			end
		end
		req       <= beat;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	initial begin
		sb           = new();
		clk          = 1'b0;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		send_gap_pct = 0;
		stall_pct    = 0;
		rand_idx     = 0;
		pressure_req = 1'b0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list cases, then build 21 0 63 42 and take it apart
		offer(1'b0, dllm_pkg::CMD_POP_FRONT, 6'd9);
		offer(1'b0, dllm_pkg::CMD_REMOVE, 6'd0);
		offer(1'b0, dllm_pkg::CMD_ADD_END, 6'd63);
		offer(1'b0, dllm_pkg::CMD_ADD_FRONT, 6'd0);
		offer(1'b0, dllm_pkg::CMD_ADD_END, 6'd42);
		offer(1'b0, dllm_pkg::CMD_ADD_FRONT, 6'd21);
		offer(1'b0, dllm_pkg::CMD_ADD_FRONT, 6'd0);
		offer(1'b0, dllm_pkg::CMD_ADD_END, 6'd63);
		offer(1'b0, dllm_pkg::CMD_REMOVE, 6'd7);
		offer(1'b0, dllm_pkg::CMD_REMOVE, 6'd0);
		offer(1'b0, dllm_pkg::CMD_REMOVE, 6'd21);
		offer(1'b0, dllm_pkg::CMD_REMOVE, 6'd42);
		offer(1'b0, dllm_pkg::CMD_POP_FRONT, 6'd63);
		offer(1'b0, dllm_pkg::CMD_ADD_FRONT, 6'd5);
		offer(1'b0, dllm_pkg::CMD_REMOVE, 6'd5);
		offer(1'b0, dllm_pkg::CMD_ADD_END, 6'd1);
		offer(1'b0, dllm_pkg::CMD_ADD_END, 6'd2);
		offer(1'b0, dllm_pkg::CMD_ADD_END, 6'd3);
		offer(1'b0, dllm_pkg::CMD_POP_FRONT, 6'd0);
		offer(1'b0, dllm_pkg::CMD_REMOVE, 6'd3);
		offer(1'b0, dllm_pkg::CMD_POP_FRONT, 6'd0);
		offer(1'b0, dllm_pkg::CMD_POP_FRONT, 6'd0);
		offer(1'b0, dllm_pkg::CMD_REMOVE, 6'd2);

		for (rand_idx = 0; rand_idx < RANDOM_BEATS; rand_idx++) begin
			case ((rand_idx / 100) % 4)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 61; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 61; end
				default: begin send_gap_pct = 6; stall_pct = 6; end
			endcase
			if (rand_idx == 40) pressure_req = 1'b1;
			offer(1'b1, dllm_pkg::CMD_ADD_FRONT, '0);
		end

		@(negedge clk);
		req_valid    <= 1'b0;
		send_gap_pct = 0;
		stall_pct    = 0;
		while (sb.owed_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.owed_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/dllm_pkg.sv
hw/rtl/dllm_ram.sv
hw/rtl/dllm_ctrl.sv
hw/rtl/dllm_dpath.sv
hw/rtl/doubly_linked_list_manager_unit.sv
tb/tb_top.sv
